FILE: rtl/bmpi_pkg.sv
// Package for the bus mouse parallel port interface.
// Holds the item type, request and port codes, the fixed register constants and the report period table.
// Depends on nothing; bmpi_ppi, bmpi_tick and the top level import it.
`default_nettype none

package bmpi_pkg;

   typedef enum logic [1:0] {
      REQ_READ   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_MOTION = 2'd2,
      REQ_TICK   = 2'd3
   } req_kind_type;

   localparam logic [2:0] PORT_A      = 3'd0;
   localparam logic [2:0] PORT_B      = 3'd1;
   localparam logic [2:0] PORT_C      = 3'd2;
   localparam logic [2:0] PORT_CTRL   = 3'd3;
   localparam logic [2:0] PORT_STATUS = 3'd4;
   localparam logic [2:0] PORT_FREQ   = 3'd5;

   localparam logic [7:0] MODE_RESET     = 8'h93;
   localparam logic [7:0] PORT_C_RESET   = 8'hF0;
   localparam logic [7:0] LATCH_RESET    = 8'hFF;
   localparam logic [7:0] LINE_STATUS    = 8'h0D;
   localparam logic [7:0] PORT_B_FORCED  = 8'h40;
   localparam logic [7:0] PORT_C_MASK    = 8'h1F;
   localparam logic [7:0] UNMAPPED_READ  = 8'hFF;
   localparam logic [3:0] PORT_C_LOW_SET = 4'h8;

   localparam int         TICK_WIDTH  = 7;
   localparam logic [6:0] TICKS_RESET = 7'(1000 / 120);

   typedef struct packed {
      req_kind_type kind;
      logic [2:0]   port_sel;
      logic [7:0]   write_data;
      logic [15:0]  move_x;
      logic [15:0]  move_y;
      logic [2:0]   buttons;
   } item_type;

   function automatic logic [TICK_WIDTH-1:0] period_ms(input logic [1:0] sel);
      logic [TICK_WIDTH-1:0] p;
      unique case (sel)
         2'd0: p = TICK_WIDTH'(1000 / 120);
         2'd1: p = TICK_WIDTH'(1000 / 60);
         2'd2: p = TICK_WIDTH'(1000 / 30);
         default: p = TICK_WIDTH'(1000 / 15);
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/bmpi_ppi.sv
// Parallel port registers, motion counters and latches of the bus mouse interface.
// Updates state on each item that advances and drives the read byte.
// Depends on bmpi_pkg.
`default_nettype none

module bmpi_ppi
   import bmpi_pkg::*;
#(
   parameter int COUNT_LIMIT = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire item_type   item,
   input  wire logic       advance,
   output logic [7:0]      read_data,
   output logic [1:0]      rate_select
);

   localparam logic signed [16:0] LIM_POS = 17'(COUNT_LIMIT);
   localparam logic signed [16:0] LIM_NEG = -17'(COUNT_LIMIT);

   logic [2:0] button_bits_ff, button_bits_in;
   logic [7:0] count_x_ff, count_x_in;
   logic [7:0] count_y_ff, count_y_in;
   logic [7:0] latched_x_ff, latched_x_in;
   logic [7:0] latched_y_ff, latched_y_in;
   logic [1:0] rate_ff, rate_in;
   logic [7:0] port_a_ff, port_a_in;
   logic [7:0] port_b_ff, port_b_in;
   logic [7:0] port_c_ff, port_c_in;
   logic [7:0] mode_ff, mode_in;

   logic [7:0] pc_new;
   logic [7:0] pc_bit;
   logic       pc_write;
   logic       is_write;
   logic [7:0] src;
   logic [7:0] pc_read;

   function automatic logic [7:0] add_sat(input logic [7:0] cnt, input logic [15:0] delta);
      logic signed [16:0] s;
      logic [7:0]         r;
      s = {{9{cnt[7]}}, cnt} + {delta[15], delta};
      if (s > LIM_POS) begin
         r = LIM_POS[7:0];
      end else if (s < LIM_NEG) begin
         r = LIM_NEG[7:0];
      end else begin
         r = s[7:0];
      end
      return r;
   endfunction

   always_comb begin
      button_bits_in = button_bits_ff;
      count_x_in     = count_x_ff;
      count_y_in     = count_y_ff;
      latched_x_in   = latched_x_ff;
      latched_y_in   = latched_y_ff;
      rate_in        = rate_ff;
      port_a_in      = port_a_ff;
      port_b_in      = port_b_ff;
      port_c_in      = port_c_ff;
      mode_in        = mode_ff;

      is_write = advance && (item.kind == REQ_WRITE);
      pc_bit   = 8'(1) << item.write_data[3:1];
      pc_new   = item.write_data;
      pc_write = 1'b0;
      if (is_write && item.port_sel == PORT_C) begin
         pc_write = 1'b1;
      end else if (is_write && item.port_sel == PORT_CTRL && !item.write_data[7]) begin
         pc_write = 1'b1;
         pc_new   = item.write_data[0] ? (port_c_ff | pc_bit) : (port_c_ff & ~pc_bit);
      end

      if (is_write) begin
         unique case (item.port_sel)
            PORT_A:    port_a_in = item.write_data;
            PORT_B:    port_b_in = item.write_data;
            PORT_CTRL: begin
               if (item.write_data[7]) begin
                  mode_in = item.write_data;
               end
            end
            PORT_FREQ: begin
               if (item.write_data[7:2] == 6'd0) begin
                  rate_in = item.write_data[1:0];
               end
            end
            default: ;
         endcase
      end

      if (pc_write) begin
         port_c_in = pc_new;
         if (!port_c_ff[7] && pc_new[7]) begin
            latched_x_in = count_x_ff;
            latched_y_in = count_y_ff;
            count_x_in   = 8'd0;
            count_y_in   = 8'd0;
         end
      end

      if (advance && item.kind == REQ_MOTION) begin
         button_bits_in = item.buttons;
         count_x_in     = add_sat(count_x_ff, item.move_x);
         count_y_in     = add_sat(count_y_ff, item.move_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_bits_ff <= 3'd0;
         count_x_ff     <= 8'd0;
         count_y_ff     <= 8'd0;
         latched_x_ff   <= LATCH_RESET;
         latched_y_ff   <= LATCH_RESET;
         rate_ff        <= 2'd0;
         port_a_ff      <= 8'h00;
         port_b_ff      <= 8'h00;
         port_c_ff      <= PORT_C_RESET;
         mode_ff        <= MODE_RESET;
      end else begin
         button_bits_ff <= button_bits_in;
         count_x_ff     <= count_x_in;
         count_y_ff     <= count_y_in;
         latched_x_ff   <= latched_x_in;
         latched_y_ff   <= latched_y_in;
         rate_ff        <= rate_in;
         port_a_ff      <= port_a_in;
         port_b_ff      <= port_b_in;
         port_c_ff      <= port_c_in;
         mode_ff        <= mode_in;
      end
   end

   always_comb begin
      unique case (port_c_ff[7:6])
         2'd0: src = count_x_ff;
         2'd1: src = count_y_ff;
         2'd2: src = latched_x_ff;
         default: src = latched_y_ff;
      endcase
      if (port_c_ff[5]) begin
         src = {4'd0, src[7:4]};
      end

      pc_read = port_c_ff;
      if (mode_ff[3]) begin
         pc_read = pc_read & PORT_C_MASK;
      end
      if (mode_ff[0]) begin
         pc_read = {pc_read[7:4], PORT_C_LOW_SET};
      end

      read_data = 8'd0;
      if (item.kind == REQ_READ) begin
         unique case (item.port_sel)
            PORT_A: begin
               if (mode_ff[4]) begin
                  read_data = {~button_bits_ff[0], ~button_bits_ff[2], ~button_bits_ff[1],
                               1'b0, src[3:0]};
               end else begin
                  read_data = port_a_ff;
               end
            end
            PORT_B:      read_data = mode_ff[1] ? PORT_B_FORCED : port_b_ff;
            PORT_C:      read_data = pc_read;
            PORT_STATUS: read_data = LINE_STATUS;
            PORT_FREQ:   read_data = {6'd0, rate_ff};
            default:     read_data = UNMAPPED_READ;
         endcase
      end
   end

   assign rate_select = rate_ff;

endmodule

`default_nettype wire

FILE: rtl/bmpi_tick.sv
// Report period timer of the bus mouse interface.
// Counts millisecond ticks down and raises the interrupt at the end of a period.
// Depends on bmpi_pkg.
`default_nettype none

module bmpi_tick
   import bmpi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       tick,
   input  wire logic [1:0] rate_select,
   output logic            irq
);

   logic [TICK_WIDTH-1:0] ticks_left_ff, ticks_left_in;

   always_comb begin
      irq           = 1'b0;
      ticks_left_in = ticks_left_ff;
      if (tick) begin
         if (ticks_left_ff <= TICK_WIDTH'(1)) begin
            irq           = 1'b1;
            ticks_left_in = period_ms(rate_select);
         end else begin
            ticks_left_in = ticks_left_ff - TICK_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_left_ff <= TICKS_RESET;
      end else begin
         ticks_left_ff <= ticks_left_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bus_mouse_ppi_interface.sv
// Top level of the bus mouse parallel port interface.
// Holds the input and result registers; depends on bmpi_pkg, bmpi_ppi and bmpi_tick.
//
// Use: each request transfer on the req_ channel is a bus read, a bus write,
// a mouse motion event or a millisecond tick, chosen by req_type. Every
// request gives exactly one response transfer on the rsp_ channel, in order:
// rsp_read_data carries the byte of a bus read and is zero otherwise;
// rsp_irq_pulse is high when a tick ends a report period.
// Path: the input register takes the item at the request transfer and the
// port logic then loads the result register from it, so each response passes
// through the input register and then the result register before rsp_valid
// rises for it.
// Throughput is one item per cycle; a request is taken in every cycle in which
// the result register is empty or being drained.
// When rsp_stall holds, the result register keeps its item and the input
// register takes one more item; req_stall rises only when both are full.
// Reset (synchronous, active high) empties both registers and returns the
// ports, counters, latches and period timer to their power-on values.
`default_nettype none

module bus_mouse_ppi_interface
   import bmpi_pkg::*;
#(
   parameter int COUNT_LIMIT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [2:0]  req_port_sel,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [15:0] req_move_x,
   input  wire logic [15:0] req_move_y,
   input  wire logic [2:0]  req_buttons,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_pulse
);

   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic       rsp_irq_ff, rsp_irq_in;

   logic       out_free;
   logic       advance;
   logic       take;
   logic [7:0] read_data;
   logic [1:0] rate_select;
   logic       irq;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (take) begin
         item_in.kind       = req_kind_type'(req_type);
         item_in.port_sel   = req_port_sel;
         item_in.write_data = req_write_data;
         item_in.move_x     = req_move_x;
         item_in.move_y     = req_move_y;
         item_in.buttons    = req_buttons;
         item_valid_in      = 1'b1;
      end

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_irq_in       = rsp_irq_ff;
      if (advance) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = read_data;
         rsp_irq_in       = irq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff          <= item_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_irq_ff       <= rsp_irq_in;
   end

   bmpi_ppi #(
      .COUNT_LIMIT (COUNT_LIMIT)
   ) u_ppi (
      .clock       (clock),
      .reset       (reset),
      .item        (item_ff),
      .advance     (advance),
      .read_data   (read_data),
      .rate_select (rate_select)
   );

   bmpi_tick u_tick (
      .clock       (clock),
      .reset       (reset),
      .tick        (advance && item_ff.kind == REQ_TICK),
      .rate_select (rate_select),
      .irq         (irq)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_irq_pulse = rsp_irq_ff;

endmodule

`default_nettype wire

FILE: rtl/bmpi_checker.sv
// Port checker for the bus mouse parallel port interface.
// Watches the top level's ports only; bound to bus_mouse_ppi_interface below.
`default_nettype none

module bmpi_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_irq_pulse
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
                                 && $stable(rsp_irq_pulse))
      else $error("stalled response transfer changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while response side is free");

   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_pulse |-> rsp_read_data == 8'h00)
      else $error("interrupt response carries read data");

endmodule

bind bus_mouse_ppi_interface bmpi_checker u_bmpi_checker (.*);

`default_nettype wire
